FILE: src/ssorlf_pkg.sv
// shared types and constants for the ssor lower factor fill block
package ssorlf_pkg;

  localparam int EPW = 8;
  localparam logic [EPW-1:0] EPOCH_MAX = '1;
  localparam logic [EPW-1:0] EPOCH_FIRST = EPW'(1);

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_ALL = 11'h7FF;

  typedef struct packed {
    logic        new_matrix;
    logic [9:0]  in_row;
    logic [9:0]  in_col;
    logic [63:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic [63:0] out_value;
    logic        status;
  } out_item_t;

  typedef enum logic [1:0] {OP_DIAG, OP_DIV, OP_MISS} op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [63:0] num;
    logic [63:0] den;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_READ, F_CHECK} front_state_t;
  typedef enum logic {B_IDLE, B_WAIT} back_state_t;
  typedef enum logic [2:0] {D_IDLE, D_NORM, D_DIV, D_SHIFT, D_ROUND} div_state_t;

endpackage

FILE: src/ssor_lower_factor_fill.sv
// top level of the ssor lower factor fill block
// Takes sparse entries in row-major order and returns one lower-factor entry for each entry on
// or below the diagonal. The front part handles one entry at a time through the steps accept,
// store read and classify, and waits in classify while the job queue is full. A sweep clears
// the store's epoch tags in all ROWS words after reset and after every 255th new_matrix. The
// back part writes a diagonal or missing-diagonal result straight into its result register; a
// division runs on an iterative divider one quotient bit per cycle, which normalises subnormal
// operands first, shifts down a subnormal quotient and sets the rate for entries below the diagonal.
module ssor_lower_factor_fill
  import ssorlf_pkg::*;
#(
  parameter int ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  logic [63:0] inv_omega_r;
  q_ctrl_t     q_ctrl;
  q_stat_t     q_stat;
  job_t        wjob, rjob;
  logic        f_push, b_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_omega_r <= 64'h3FF0_0000_0000_0000;
    end else if (cfg_we) begin
      inv_omega_r <= cfg_wdata;
    end
  end

  assign q_ctrl.push = f_push;
  assign q_ctrl.pop  = b_pop;

  ssorlf_front #(.ROWS(ROWS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_push  (f_push),
    .q_job   (wjob)
  );

  ssorlf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .wjob  (wjob),
    .rjob  (rjob),
    .stat  (q_stat)
  );

  ssorlf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (rjob),
    .q_pop     (b_pop),
    .inv_omega (inv_omega_r),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );
endmodule

FILE: src/ssorlf_queue.sv
// two-entry job queue between the front and back parts
module ssorlf_queue
  import ssorlf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctrl_t ctrl,
  input  job_t    wjob,
  output job_t    rjob,
  output q_stat_t stat
);
  job_t       ent_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;
  assign rjob       = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= wjob;
    end
  end
endmodule

FILE: src/ssorlf_front.sv
// front part: accepts entries, keeps the diagonal store and classifies entries into jobs
module ssorlf_front
  import ssorlf_pkg::*;
#(
  parameter int ROWS = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output job_t     q_job
);
  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MW = EPW + 64;

  // each word carries the epoch in which it was written; tag zero is never live
  logic [MW-1:0] mem [ROWS];

  front_state_t   state_r, state_nxt;
  in_item_t       item_r, item_nxt;
  logic [EPW-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic           pend_r, pend_nxt;
  logic [MW-1:0]  rdata_r;

  logic           we, re;
  logic [AW-1:0]  waddr, addr;
  logic [MW-1:0]  wdata;
  logic           in_range, hit, is_diag, is_upper;

  assign addr     = AW'(item_r.in_col);
  assign in_range = (32'(item_r.in_col) < 32'(ROWS));
  assign hit      = in_range && (rdata_r[MW-1:64] == epoch_r);
  assign is_diag  = (item_r.in_col == item_r.in_row);
  assign is_upper = (item_r.in_col > item_r.in_row);

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    epoch_nxt = epoch_r;
    clr_nxt   = clr_r;
    pend_nxt  = pend_r;
    full      = 1'b1;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = addr;
    wdata     = {epoch_r, item_r.in_value};
    q_push    = 1'b0;
    q_job.kind = OP_DIAG;
    q_job.row  = item_r.in_row;
    q_job.col  = item_r.in_col;
    q_job.num  = item_r.in_value;
    q_job.den  = rdata_r[63:0];
    unique case (state_r)
      F_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(ROWS - 1)) begin
          clr_nxt   = '0;
          epoch_nxt = EPOCH_FIRST;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? F_READ : F_IDLE;
        end
      end
      F_IDLE: begin
        full = 1'b0;
        if (push) begin
          item_nxt  = in_item;
          state_nxt = F_READ;
          if (in_item.new_matrix) begin
            // epoch wrap needs the store swept back to tag zero
            if (epoch_r == EPOCH_MAX) begin
              pend_nxt  = 1'b1;
              state_nxt = F_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPW'(1);
            end
          end
        end
      end
      F_READ: begin
        re        = 1'b1;
        state_nxt = F_CHECK;
      end
      F_CHECK: begin
        if (is_upper) begin
          state_nxt = F_IDLE;
        end else begin
          q_push = 1'b1;
          if (is_diag) begin
            q_job.kind = OP_DIAG;
          end else begin
            q_job.kind = hit ? OP_DIV : OP_MISS;
          end
          if (!q_stat.full) begin
            state_nxt = F_IDLE;
            if (is_diag && in_range && !hit) begin
              we = 1'b1;
            end
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_CLEAR;
      epoch_r <= EPOCH_FIRST;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      epoch_r <= epoch_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end
endmodule

FILE: src/ssorlf_div.sv
// iterative ieee double divider, one quotient bit per cycle, round to nearest even
module ssorlf_div
  import ssorlf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] result
);
  div_state_t          state_r, state_nxt;
  logic [52:0]         ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [13:0]  ea_r, ea_nxt, eb_r, eb_nxt, e_r, e_nxt;
  logic [54:0]         rem_r, rem_nxt;
  logic [53:0]         q_r, q_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                sticky_r, sticky_nxt, sign_r, sign_nxt;
  logic                done_r, done_nxt;
  logic [63:0]         res_r, res_nxt;

  logic [10:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [54:0] rem_sub;
  logic        rnd;
  logic [53:0] mant54;
  logic [52:0] mfin;
  logic signed [13:0] efin, etmp;

  assign done   = done_r;
  assign result = res_r;

  always_comb begin
    fa     = num[62:52];
    fb     = den[62:52];
    a_nan  = (fa == EXP_ALL) && (num[51:0] != '0);
    b_nan  = (fb == EXP_ALL) && (den[51:0] != '0);
    a_inf  = (fa == EXP_ALL) && (num[51:0] == '0);
    b_inf  = (fb == EXP_ALL) && (den[51:0] == '0);
    a_zero = (num[62:0] == '0);
    b_zero = (den[62:0] == '0);
    sgn    = num[63] ^ den[63];
    rem_sub = rem_r - {2'b00, mb_r};
    rnd    = q_r[0] && (sticky_r || q_r[1]);
    mant54 = {1'b0, q_r[53:1]} + 54'(rnd);
    if (mant54[53]) begin
      mfin = mant54[53:1];
      efin = e_r + 14'sd1;
    end else begin
      mfin = mant54[52:0];
      efin = e_r;
    end
    etmp = ea_r - eb_r + 14'sd1023;
  end

  always_comb begin
    state_nxt  = state_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    ea_nxt     = ea_r;
    eb_nxt     = eb_r;
    e_nxt      = e_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    sticky_nxt = sticky_r;
    sign_nxt   = sign_r;
    done_nxt   = 1'b0;
    res_nxt    = res_r;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          sign_nxt = sgn;
          ma_nxt   = {(fa != '0), num[51:0]};
          mb_nxt   = {(fb != '0), den[51:0]};
          ea_nxt   = (fa == '0) ? 14'sd1 : $signed({3'b000, fa});
          eb_nxt   = (fb == '0) ? 14'sd1 : $signed({3'b000, fb});
          done_nxt = 1'b1;
          if (b_zero) begin
            res_nxt = (a_zero || a_nan) ? QNAN_BITS : {sgn, EXP_ALL, 52'd0};
          end else if (a_nan || b_nan || (a_inf && b_inf)) begin
            res_nxt = QNAN_BITS;
          end else if (a_inf) begin
            res_nxt = {sgn, EXP_ALL, 52'd0};
          end else if (b_inf || a_zero) begin
            res_nxt = {sgn, 63'd0};
          end else begin
            done_nxt  = 1'b0;
            state_nxt = D_NORM;
          end
        end
      end
      D_NORM: begin
        // subnormal operands are brought up one bit a cycle
        if (!ma_r[52] || !mb_r[52]) begin
          if (!ma_r[52]) begin
            ma_nxt = {ma_r[51:0], 1'b0};
            ea_nxt = ea_r - 14'sd1;
          end
          if (!mb_r[52]) begin
            mb_nxt = {mb_r[51:0], 1'b0};
            eb_nxt = eb_r - 14'sd1;
          end
        end else begin
          cnt_nxt = '0;
          q_nxt   = '0;
          if (ma_r < mb_r) begin
            rem_nxt = {1'b0, ma_r, 1'b0};
            e_nxt   = etmp - 14'sd1;
          end else begin
            rem_nxt = {2'b00, ma_r};
            e_nxt   = etmp;
          end
          state_nxt = D_DIV;
        end
      end
      D_DIV: begin
        if (!rem_sub[54]) begin
          q_nxt   = {q_r[52:0], 1'b1};
          rem_nxt = {rem_sub[53:0], 1'b0};
        end else begin
          q_nxt   = {q_r[52:0], 1'b0};
          rem_nxt = {rem_r[53:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd53) begin
          state_nxt = D_SHIFT;
        end
      end
      D_SHIFT: begin
        if (cnt_r == 6'd54) begin
          sticky_nxt = (rem_r != '0);
          cnt_nxt    = '0;
        end else if (e_r < 14'sd1) begin
          if (e_r < -14'sd60) begin
            q_nxt      = '0;
            sticky_nxt = 1'b1;
            e_nxt      = 14'sd1;
          end else begin
            sticky_nxt = sticky_r | q_r[0];
            q_nxt      = {1'b0, q_r[53:1]};
            e_nxt      = e_r + 14'sd1;
          end
        end else begin
          state_nxt = D_ROUND;
        end
      end
      D_ROUND: begin
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
        if (efin >= 14'sd2047) begin
          res_nxt = {sign_r, EXP_ALL, 52'd0};
        end else begin
          res_nxt = {sign_r, (mfin[52] ? efin[10:0] : 11'd0), mfin[51:0]};
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    e_r      <= e_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
    sticky_r <= sticky_nxt;
    sign_r   <= sign_nxt;
    res_r    <= res_nxt;
  end
endmodule

FILE: src/ssorlf_back.sv
// back part: carries out queued jobs and holds the result register
module ssorlf_back
  import ssorlf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  job_t        q_job,
  output logic        q_pop,
  input  logic [63:0] inv_omega,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item
);
  back_state_t state_r, state_nxt;
  logic        val_r, val_nxt;
  out_item_t   out_r, out_nxt;
  logic [9:0]  row_r, row_nxt, col_r, col_nxt;
  logic        slot_free, div_start, div_done;
  logic [63:0] div_res;

  ssorlf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (q_job.num),
    .den    (q_job.den),
    .done   (div_done),
    .result (div_res)
  );

  assign empty     = !val_r;
  assign out_item  = out_r;
  assign slot_free = !val_r || pop;

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r && !pop;
    out_nxt   = out_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty && slot_free) begin
          q_pop = 1'b1;
          case (q_job.kind)
            OP_DIAG: begin
              out_nxt = '{out_row: q_job.row, out_col: q_job.col,
                          out_value: inv_omega, status: 1'b0};
              val_nxt = 1'b1;
            end
            OP_MISS: begin
              out_nxt = '{out_row: q_job.row, out_col: q_job.col,
                          out_value: 64'd0, status: 1'b1};
              val_nxt = 1'b1;
            end
            default: begin
              div_start = 1'b1;
              row_nxt   = q_job.row;
              col_nxt   = q_job.col;
              state_nxt = B_WAIT;
            end
          endcase
        end
      end
      B_WAIT: begin
        // result slot was free at start and nothing else fills it meanwhile
        if (div_done) begin
          out_nxt = '{out_row: row_r, out_col: col_r, out_value: div_res, status: 1'b0};
          val_nxt   = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      val_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      val_r   <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
  end
endmodule

FILE: tb/sv/ssorlf_checker.sv
// checker for the ssor lower factor fill block: predicts factor entries and compares them
`timescale 1ns / 100ps

module ssorlf_checker
  import ssorlf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  in_item_t    in_item,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  output int          fails,
  output int          pending,
  output int          n_div,
  output int          n_diag,
  output int          n_miss
);

  localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
  localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;

  logic [63:0] inv_omega;
  logic [63:0] diag_val [0:1023];
  logic        diag_seen [0:1023];
  out_item_t   factor_q [$];

  function automatic logic is_nan(logic [63:0] b);
    return b[62:52] == EXP_ALL && b[51:0] != 0;
  endfunction

  // double division, round to nearest even, with NaN made canonical
  function automatic logic [63:0] quotient(logic [63:0] num, logic [63:0] den);
    real a;
    real b;
    logic [63:0] r;
    if ((den & ~SIGN_MASK) == 0) begin
      if ((num & ~SIGN_MASK) == 0 || is_nan(num)) return QNAN_BITS;
      return ((num ^ den) & SIGN_MASK) | EXP_MASK;
    end
    a = $bitstoreal(num);
    b = $bitstoreal(den);
    r = $realtobits(a / b);
    if (is_nan(r)) return QNAN_BITS;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      inv_omega = 64'h3FF0_0000_0000_0000;
      for (int i = 0; i < 1024; i++) diag_seen[i] = 1'b0;
      factor_q.delete();
      fails = 0;
      n_div = 0;
      n_diag = 0;
      n_miss = 0;
    end else begin
      if (cfg_we) inv_omega = cfg_wdata;
      if (pop && !empty) begin
        if (factor_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_item.out_value, 64'd0);
        end else begin
          e = factor_q.pop_front();
          if (out_item.out_row !== e.out_row)
            report_mismatch("row", 64'(out_item.out_row), 64'(e.out_row));
          if (out_item.out_col !== e.out_col)
            report_mismatch("col", 64'(out_item.out_col), 64'(e.out_col));
          if (out_item.out_value !== e.out_value)
            report_mismatch("value", out_item.out_value, e.out_value);
          if (out_item.status !== e.status)
            report_mismatch("status", 64'(out_item.status), 64'(e.status));
        end
      end
      if (push && !full) begin
        if (in_item.new_matrix)
          for (int i = 0; i < 1024; i++) diag_seen[i] = 1'b0;
        if (in_item.in_col <= in_item.in_row) begin
          e.out_row = in_item.in_row;
          e.out_col = in_item.in_col;
          if (in_item.in_col == in_item.in_row) begin
            if (!diag_seen[in_item.in_row]) begin
              diag_val[in_item.in_row] = in_item.in_value;
              diag_seen[in_item.in_row] = 1'b1;
            end
            e.out_value = inv_omega;
            e.status = 1'b0;
            n_diag++;
          end else if (diag_seen[in_item.in_col]) begin
            e.out_value = quotient(in_item.in_value, diag_val[in_item.in_col]);
            e.status = 1'b0;
            n_div++;
          end else begin
            e.out_value = '0;
            e.status = 1'b1;
            n_miss++;
          end
          factor_q.push_back(e);
        end
      end
    end
    pending <= factor_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// top of the ssor lower factor fill testbench: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module testbench;
  import ssorlf_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 1300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  int fails, pending, n_div, n_diag, n_miss;
  int cycles = 0;
  int entries_sent = 0;
  int pop_stall = 0;
  logic idle_on = 1'b1;
  logic start_matrix = 1'b1;

  always #6 clk = ~clk;

  ssor_lower_factor_fill u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  ssorlf_checker u_check (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending), .n_div(n_div), .n_diag(n_diag), .n_miss(n_miss)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ssor_lower_factor_fill verification failed");
      $finish;
    end
  end

  // result side: stall in bursts while idle_on is set
  always @(posedge clk) begin
    if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      pop_stall <= $urandom_range(0, 6);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ;
      1: v = {v[63], 63'h0};
      2: v = {v[63], 11'h7FF, 52'h0};
      3: v = {v[63], 11'h7FF, v[51:1], 1'b1};
      4: v = {v[63], 11'h000, v[51:1], 1'b1};
      default: v[62:52] = 11'($urandom_range(1023 - 60, 1023 + 60));
    endcase
    return v;
  endfunction

  task automatic send(logic nm, logic [9:0] row, logic [9:0] col, logic [63:0] val);
    in_item_t it;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    it.new_matrix = nm;
    it.in_row = row;
    it.in_col = col;
    it.in_value = val;
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    entries_sent++;
  endtask

  task automatic send_entry(int row, int col, logic [63:0] val);
    send(start_matrix, row[9:0], col[9:0], val);
    start_matrix = 1'b0;
  endtask

  // one small matrix in row-major order, with some broken rows and noise
  task automatic send_matrix();
    int rows[$];
    int r;
    r = $urandom_range(0, 120);
    for (int i = 0; i < $urandom_range(2, 8) && r <= 1023; i++) begin
      rows.push_back(r);
      r += $urandom_range(1, 140);
    end
    if ($urandom_range(0, 3) == 0 && rows[$] < 1023) rows.push_back(1023);
    start_matrix = 1'b1;
    foreach (rows[i]) begin
      if ($urandom_range(0, 9) == 0)
        send({$urandom} % 2 == 0, 10'($urandom), 10'($urandom), rand_double());
      for (int j = 0; j < i; j++)
        if ($urandom_range(0, 2) != 0) send_entry(rows[i], rows[j], rand_double());
      if ($urandom_range(0, 7) == 0) send_entry(rows[i], $urandom_range(0, rows[i] - 1),
                                                rand_double());
      if ($urandom_range(0, 9) != 0) send_entry(rows[i], rows[i], rand_double());
      if ($urandom_range(0, 5) == 0) send_entry(rows[i], rows[i], rand_double());
      if (rows[i] < 1023)
        repeat ($urandom_range(0, 2))
          send_entry(rows[i], $urandom_range(rows[i] + 1, 1023), rand_double());
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_omega(logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int target);
    int stop_at;
    stop_at = entries_sent + target;
    while (entries_sent < stop_at) send_matrix();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset value of the omega register
    send(1'b1, 10'd0, 10'd0, 64'h4000_0000_0000_0000);
    send(1'b0, 10'd1, 10'd0, 64'h3FF0_0000_0000_0000);
    send(1'b0, 10'd1, 10'd1, 64'h8000_0000_0000_0000);
    send(1'b0, 10'd2, 10'd1, 64'h4014_0000_0000_0000);
    send(1'b0, 10'd2, 10'd1, 64'h0000_0000_0000_0000);
    send(1'b0, 10'd2, 10'd0, 64'hFFEF_FFFF_FFFF_FFFF);
    send(1'b0, 10'd2, 10'd2, 64'h7FF0_0000_0000_0000);
    send(1'b0, 10'd2, 10'd2, 64'h3FF0_0000_0000_0000);
    send(1'b0, 10'd3, 10'd2, 64'h4014_0000_0000_0000);
    send(1'b0, 10'd3, 10'd2, 64'h7FF0_0000_0000_0000);
    send(1'b0, 10'd5, 10'd4, 64'h3FF0_0000_0000_0000);
    send(1'b0, 10'd5, 10'd9, 64'h3FF0_0000_0000_0000);
    send(1'b0, 10'd1023, 10'd0, 64'h0000_0000_0000_0001);
    send(1'b0, 10'd1023, 10'd1022, 64'h3FF0_0000_0000_0000);
    send(1'b0, 10'd1023, 10'd1023, 64'hFFFF_FFFF_FFFF_FFFF);
    send(1'b1, 10'd0, 10'd0, 64'h0000_0000_0000_0000);
    send(1'b0, 10'd0, 10'd1023, 64'h3FF0_0000_0000_0000);
    send(1'b0, 10'd1, 10'd0, 64'h0000_0000_0000_0000);
    send(1'b0, 10'd1, 10'd0, 64'h7FF8_0000_0000_0001);
    send(1'b0, 10'd1, 10'd0, 64'hFFF0_0000_0000_0000);
    send(1'b0, 10'd1, 10'd1, 64'h0000_0000_0000_0001);
    send(1'b0, 10'd2, 10'd1, 64'h3FF0_0000_0000_0000);
    send(1'b0, 10'd2, 10'd1, 64'h0010_0000_0000_0000);
    send(1'b1, 10'd3, 10'd0, 64'h3FF0_0000_0000_0000);
    drain();

    write_omega(64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(400);
    drain();
    write_omega(64'h0);
    random_phase(400);
    drain();
    write_omega({$urandom, $urandom});
    idle_on = 1'b0;
    random_phase(450);
    drain();

    $display("%0d entries sent: %0d divisions, %0d diagonals, %0d missing diagonals checked",
             entries_sent, n_div, n_diag, n_miss);
    $display("omega register at reset value, all ones, zero and a random value");
    if (fails == 0 && pending == 0) begin
      $display("ssor_lower_factor_fill verification clean");
    end else begin
      $display("ssor_lower_factor_fill verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ssorlf_pkg.sv
src/ssorlf_queue.sv
src/ssorlf_front.sv
src/ssorlf_div.sv
src/ssorlf_back.sv
src/ssor_lower_factor_fill.sv
tb/sv/ssorlf_checker.sv
tb/sv/testbench.sv
